// ===== src/sfpp_pkg.sv =====
// Shared types and constants for the sync framed packet parser.
`timescale 1ns / 1ps
`default_nettype none

package sfpp_pkg;

    // Framing bytes
    localparam logic [7:0] SYNC_BYTE    = 8'hAA;
    localparam logic [7:0] ALT_LEN_CODE = 8'h6A;
    localparam logic [7:0] CR_BYTE      = 8'd13;
    localparam logic [7:0] LF_BYTE      = 8'd10;
    localparam logic [7:0] MIN_LEN      = 8'd1;

    // Register reset values
    localparam logic [7:0] SHORT_LEN_RST = 8'd67;
    localparam logic [7:0] LONG_LEN_RST  = 8'd76;
    localparam logic [7:0] ALT_LEN_RST   = 8'd64;

    // Port widths
    localparam int CFG_INDEX_W = 2;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SHORT_LEN = 2'd0,
        REG_LONG_LEN  = 2'd1,
        REG_ALT_LEN   = 2'd2
    } cfg_index_t;

    // Frame status codes
    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_PACKET   = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_ALT_DONE = 2'd3
    } frame_status_t;

    // Parser phases, one-hot
    typedef enum logic [7:0] {
        PH_SYNC  = 8'b0000_0001,
        PH_LEN   = 8'b0000_0010,
        PH_ALT   = 8'b0000_0100,
        PH_DATA  = 8'b0000_1000,
        PH_SUM   = 8'b0001_0000,
        PH_SUMHI = 8'b0010_0000,
        PH_CR    = 8'b0100_0000,
        PH_LF    = 8'b1000_0000
    } phase_t;

    // Active configuration
    typedef struct packed {
        logic [7:0] short_frame_length;
        logic [7:0] long_frame_length;
        logic [7:0] alternate_payload_length;
    } cfg_t;

    // One result word
    typedef struct packed {
        logic [7:0]    received_sum_low;
        logic [7:0]    expected_sum_low;
        logic [7:0]    bad_frame_length;
        logic [7:0]    payload_byte;
        logic [6:0]    payload_index;
        logic          byte_captured;
        frame_status_t frame_status;
    } result_t;

endpackage

`default_nettype wire

// ===== src/sfpp_cfg_regs.sv =====
// Configuration register file for the packet parser.
`timescale 1ns / 1ps
`default_nettype none

module sfpp_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [sfpp_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [7:0]                       wr_data,
    output sfpp_pkg::cfg_t                        cfg
);

    sfpp_pkg::cfg_t cfg_reg;
    sfpp_pkg::cfg_t cfg_next;

    // Decode the write index; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                sfpp_pkg::REG_SHORT_LEN: cfg_next.short_frame_length       = wr_data;
                sfpp_pkg::REG_LONG_LEN:  cfg_next.long_frame_length        = wr_data;
                sfpp_pkg::REG_ALT_LEN:   cfg_next.alternate_payload_length = wr_data;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_frame_length       <= sfpp_pkg::SHORT_LEN_RST;
            cfg_reg.long_frame_length        <= sfpp_pkg::LONG_LEN_RST;
            cfg_reg.alternate_payload_length <= sfpp_pkg::ALT_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== src/sfpp_parser.sv =====
// Frame state and per-byte parse logic.
`timescale 1ns / 1ps
`default_nettype none

module sfpp_parser #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step_en,
    input  wire logic [7:0]     rx_byte,
    input  sfpp_pkg::cfg_t      cfg,
    output sfpp_pkg::result_t   result
);

    localparam logic [8:0] CAP_LIMIT = 9'(BUFFER_BYTES);

    sfpp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       count_reg, count_next;
    logic [7:0]       flen_reg, flen_next;
    logic [15:0]      sum_reg, sum_next;
    logic [7:0]       sumlo_reg, sumlo_next;

    logic [7:0]       count_inc;
    logic             can_capture;
    logic [7:0]       reject_count;

    assign count_inc    = count_reg + 8'd1;
    assign can_capture  = {1'b0, count_reg} < CAP_LIMIT;
    assign reject_count = (rx_byte == sfpp_pkg::SYNC_BYTE) ? 8'd1 : 8'd0;

    // Next state and result for the byte at hand
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        flen_next  = flen_reg;
        sum_next   = sum_reg;
        sumlo_next = sumlo_reg;
        result     = '0;

        case (phase_reg)
            sfpp_pkg::PH_SYNC:
            begin
                if (rx_byte != sfpp_pkg::SYNC_BYTE)
                    count_next = 8'd0;
                else if (count_reg == 8'd2)
                    phase_next = sfpp_pkg::PH_LEN;
                else
                    count_next = count_inc;
            end
            sfpp_pkg::PH_LEN:
            begin
                count_next = 8'd0;
                if (rx_byte == sfpp_pkg::ALT_LEN_CODE)
                begin
                    flen_next  = cfg.alternate_payload_length;
                    phase_next = sfpp_pkg::PH_ALT;
                end
                else if (rx_byte == sfpp_pkg::MIN_LEN
                         || rx_byte == cfg.short_frame_length
                         || rx_byte == cfg.long_frame_length)
                begin
                    flen_next  = rx_byte;
                    phase_next = sfpp_pkg::PH_DATA;
                end
                else
                begin
                    // Rejected length: count stays cleared
                    phase_next = sfpp_pkg::PH_SYNC;
                    flen_next  = 8'd0;
                    sum_next   = 16'd0;
                    sumlo_next = 8'd0;
                end
            end
            sfpp_pkg::PH_ALT:
            begin
                result.byte_captured = can_capture;
                result.payload_index = can_capture ? count_reg[6:0] : 7'd0;
                result.payload_byte  = can_capture ? rx_byte : 8'd0;
                count_next = count_inc;
                if (count_inc == flen_reg)
                begin
                    count_next          = 8'd0;
                    sum_next            = 16'd0;
                    sumlo_next          = 8'd0;
                    phase_next          = sfpp_pkg::PH_SYNC;
                    result.frame_status = sfpp_pkg::ST_ALT_DONE;
                end
            end
            sfpp_pkg::PH_DATA:
            begin
                result.byte_captured = can_capture;
                result.payload_index = can_capture ? count_reg[6:0] : 7'd0;
                result.payload_byte  = can_capture ? rx_byte : 8'd0;
                count_next = count_inc;
                sum_next   = sum_reg + {8'd0, rx_byte};
                if (count_inc == flen_reg)
                    phase_next = sfpp_pkg::PH_SUM;
            end
            sfpp_pkg::PH_SUM:
            begin
                if (flen_reg == cfg.long_frame_length)
                begin
                    sumlo_next = rx_byte;
                    phase_next = sfpp_pkg::PH_SUMHI;
                end
                else if (sum_reg[7:0] == rx_byte)
                begin
                    count_next          = 8'd0;
                    sum_next            = 16'd0;
                    sumlo_next          = 8'd0;
                    phase_next          = sfpp_pkg::PH_SYNC;
                    result.frame_status = sfpp_pkg::ST_PACKET;
                end
                else
                begin
                    result.frame_status     = sfpp_pkg::ST_MISMATCH;
                    result.bad_frame_length = flen_reg;
                    result.expected_sum_low = sum_reg[7:0];
                    result.received_sum_low = rx_byte;
                    phase_next = sfpp_pkg::PH_SYNC;
                    count_next = reject_count;
                    flen_next  = 8'd0;
                    sum_next   = 16'd0;
                    sumlo_next = 8'd0;
                end
            end
            sfpp_pkg::PH_SUMHI:
            begin
                if ({rx_byte, sumlo_reg} == sum_reg)
                    phase_next = sfpp_pkg::PH_CR;
                else
                begin
                    result.frame_status     = sfpp_pkg::ST_MISMATCH;
                    result.bad_frame_length = flen_reg;
                    result.expected_sum_low = sum_reg[7:0];
                    result.received_sum_low = sumlo_reg;
                    phase_next = sfpp_pkg::PH_SYNC;
                    count_next = reject_count;
                    flen_next  = 8'd0;
                    sum_next   = 16'd0;
                    sumlo_next = 8'd0;
                end
            end
            sfpp_pkg::PH_CR:
            begin
                if (rx_byte == sfpp_pkg::CR_BYTE)
                    phase_next = sfpp_pkg::PH_LF;
                else
                begin
                    phase_next = sfpp_pkg::PH_SYNC;
                    count_next = reject_count;
                    flen_next  = 8'd0;
                    sum_next   = 16'd0;
                    sumlo_next = 8'd0;
                end
            end
            sfpp_pkg::PH_LF:
            begin
                phase_next = sfpp_pkg::PH_SYNC;
                sum_next   = 16'd0;
                sumlo_next = 8'd0;
                if (rx_byte == sfpp_pkg::LF_BYTE)
                begin
                    count_next          = 8'd0;
                    result.frame_status = sfpp_pkg::ST_PACKET;
                end
                else
                begin
                    count_next = reject_count;
                    flen_next  = 8'd0;
                end
            end
            default:
            begin
                phase_next = sfpp_pkg::PH_SYNC;
                count_next = 8'd0;
                flen_next  = 8'd0;
                sum_next   = 16'd0;
                sumlo_next = 8'd0;
            end
        endcase
    end

    // Advance frame state once per consumed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sfpp_pkg::PH_SYNC;
            count_reg <= 8'd0;
            flen_reg  <= 8'd0;
            sum_reg   <= 16'd0;
            sumlo_reg <= 8'd0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            flen_reg  <= flen_next;
            sum_reg   <= sum_next;
            sumlo_reg <= sumlo_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/sync_framed_packet_parser_top.sv =====
// Top level of the sync framed packet parser: stream ports, word registers.
`timescale 1ns / 1ps
`default_nettype none

// Sync framed packet parser. Each input word is one received byte; each input
// word produces exactly one output word with the frame status and, for payload
// bytes, the captured byte and its index. Throughput is one byte per clock
// while m_tready stays high: a byte is registered on input, parsed by
// combinational next-state logic and the result registered on output, from
// where it is taken when m_tready is high. While an untaken result sits in
// the output register, one more byte can be accepted into the input register;
// after that s_tready stays low until the output word is taken, so at most
// two words are held inside the block, one in each register.
// Configuration registers (0 short length, 1 long length, 2 alternate payload
// length) are written through the cfg port and should only change while no
// bytes are in flight. BUFFER_BYTES sets how many payload bytes per frame are
// reported as captured.
module sync_framed_packet_parser_top #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [sfpp_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] rx_byte
    // Output stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] frame_status, [2] byte_captured, [9:3] payload_index,
    // [17:10] payload_byte, [25:18] bad_frame_length,
    // [33:26] expected_sum_low, [41:34] received_sum_low, [47:42] zero
    output logic [sfpp_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sfpp_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [7:0]                          cfg_data
);

    sfpp_pkg::cfg_t    cfg;
    sfpp_pkg::result_t step_result;

    logic              in_valid_reg, in_valid_next;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg, out_valid_next;
    sfpp_pkg::result_t out_result_reg;
    logic              advance;
    logic              step_en;

    assign cfg_ready = 1'b1;

    sfpp_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Output register frees up when empty or taken
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    sfpp_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // Hold word valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input byte and parse result
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
        if (step_en)
            out_result_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_result_reg};

endmodule

`default_nettype wire
